/* sv/cvs_pkg.sv */
// Shared constants and types for the chunked voxel store.
`default_nettype none
package cvs_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SL_W        = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int CHUNK_EDGE  = 16;
    localparam int CE_LOG      = $clog2(CHUNK_EDGE);
    localparam int KEY_W       = 32 - CE_LOG;
    localparam int LOC_W       = 3 * CE_LOG;
    localparam int VA_W        = SL_W + LOC_W;
    localparam int VOX_DEPTH   = 1 << VA_W;
    localparam int BLK_W       = 3;

    // A new key is refused once occupancy plus one reaches three quarters.
    localparam logic [CNT_W:0] LOAD_LIMIT = (CNT_W + 1)'((3 * TABLE_SLOTS + 3) / 4);

    localparam logic [BLK_W-1:0] MAX_BLOCK = 3'd5;
    localparam logic [BLK_W-1:0] BLK_AIR   = 3'd0;

    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_UNLOAD = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_BADBLK = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] MIX_MULT  = 32'h2c1b3c6d;

    typedef struct packed {
        logic [KEY_W-1:0] kx;
        logic [KEY_W-1:0] ky;
        logic [KEY_W-1:0] kz;
        logic [SL_W-1:0]  buf_idx;
    } t_slot;

endpackage
`default_nettype wire

/* sv/cvs_hash.sv */
// Iterative FNV-1a hash with avalanche, one multiply per cycle.
`default_nettype none
module cvs_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_key_x,
    input  wire logic [31:0] i_key_y,
    input  wire logic [31:0] i_key_z,
    output logic             o_done,
    output logic [31:0]      o_hash
);
    import cvs_pkg::*;

    localparam logic [2:0] HS_IDLE = 3'd0;
    localparam logic [2:0] HS_X    = 3'd1;
    localparam logic [2:0] HS_Y    = 3'd2;
    localparam logic [2:0] HS_Z    = 3'd3;
    localparam logic [2:0] HS_MIX  = 3'd4;
    localparam logic [2:0] HS_FIN  = 3'd5;

    logic [2:0]  r_step;
    logic        r_done;
    logic [31:0] r_h, r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= HS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_step)
                HS_IDLE: begin
                    if (i_start) begin
                        r_h    <= FNV_BASIS;
                        r_x    <= i_key_x;
                        r_y    <= i_key_y;
                        r_z    <= i_key_z;
                        r_step <= HS_X;
                    end
                end
                HS_X: begin
                    r_h    <= (r_h ^ r_x) * FNV_PRIME;
                    r_step <= HS_Y;
                end
                HS_Y: begin
                    r_h    <= (r_h ^ r_y) * FNV_PRIME;
                    r_step <= HS_Z;
                end
                HS_Z: begin
                    r_h    <= (r_h ^ r_z) * FNV_PRIME;
                    r_step <= HS_MIX;
                end
                HS_MIX: begin
                    r_h    <= (r_h ^ (r_h >> 15)) * MIX_MULT;
                    r_step <= HS_FIN;
                end
                HS_FIN: begin
                    r_h    <= r_h ^ (r_h >> 12);
                    r_done <= 1'b1;
                    r_step <= HS_IDLE;
                end
                default: r_step <= HS_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;

endmodule
`default_nettype wire

/* sv/chunked_voxel_store_hash_directory.sv */
// Top level of the chunked voxel store with its hashed chunk directory.
`default_nettype none
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_ready | i_mode, i_coord_x/y/z, i_block_value
// out     | output    | o_out_valid / i_out_ready | o_status, o_read_value,
//         |           |                         | o_chunks_present, o_chunks_filled
//
// One item is worked on at a time. It is hashed first, then the directory is probed slot by slot,
// each probe step reading the slot and then comparing its key; a get or set without a buffer clear
// shows its result once the probe ends, with one more probe step for every occupied slot passed.
// A set that takes a fresh buffer first clears all 4096 of its voxels, one voxel per cycle.
// An unload walks the chain behind the freed slot, and the iterative hash unit rehashes
// the key of every occupied slot it visits.
// Reset is synchronous; it clears the directory valid bits and counters and refills the free stack.
// A finished result sits in the output register, and the next item is taken meanwhile.
module chunked_voxel_store_hash_directory (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_mode,
    input  wire logic signed [31:0]      i_coord_x,
    input  wire logic signed [31:0]      i_coord_y,
    input  wire logic signed [31:0]      i_coord_z,
    input  wire logic [2:0]              i_block_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_status,
    output logic [2:0]                   o_read_value,
    output logic [4:0]                   o_chunks_present,
    output logic [4:0]                   o_chunks_filled
);
    import cvs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_PRD   = 4'd2;
    localparam logic [3:0] S_PCMP  = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_CLR   = 4'd5;
    localparam logic [3:0] S_VWR   = 4'd6;
    localparam logic [3:0] S_VRD   = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SKEY  = 4'd9;
    localparam logic [3:0] S_SHASH = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    // Item and control registers.
    logic [3:0]             r_state;
    logic [1:0]             r_mode;
    logic [BLK_W-1:0]       r_blk;
    logic [KEY_W-1:0]       r_cx, r_cy, r_cz;
    logic [LOC_W-1:0]       r_loc;
    logic [SL_W-1:0]        r_idx, r_hole, r_buf;
    logic [CNT_W-1:0]       r_n;
    logic                   r_hit;
    logic [LOC_W-1:0]       r_clr;
    logic [1:0]             r_status;
    logic [BLK_W-1:0]       r_readv;

    // Directory bookkeeping held in flops.
    logic [TABLE_SLOTS-1:0] r_used, r_has;
    logic [SL_W-1:0]        r_stack [TABLE_SLOTS];
    logic [CNT_W-1:0]       r_top, r_occ, r_filled;

    // Output register.
    logic                   r_ovalid;
    logic [1:0]             r_ostat;
    logic [BLK_W-1:0]       r_oread;
    logic [CNT_W-1:0]       r_opres, r_ofill;

    // Memories: directory entries and the voxel pool.
    t_slot                  m_slot [TABLE_SLOTS];
    logic [BLK_W-1:0]       m_vox  [VOX_DEPTH];
    t_slot                  r_rd;
    logic [BLK_W-1:0]       r_vrd;

    logic                   s_slot_re, s_slot_we;
    logic [SL_W-1:0]        s_slot_waddr;
    t_slot                  s_slot_wdata;
    logic                   s_vwe, s_vre;
    logic [VA_W-1:0]        s_vaddr;
    logic [BLK_W-1:0]       s_vdata;

    logic                   s_hash_start, s_hash_done;
    logic [31:0]            s_hx, s_hy, s_hz, s_hash;

    logic                   s_accept, s_full, s_has_now, s_need_alloc, s_can_alloc;
    logic                   s_key_eq, s_in_range, s_out_load;
    logic [SL_W-1:0]        s_pop, s_home;

    assign s_accept    = i_in_valid && o_in_ready;
    assign s_full      = ({1'b0, r_occ} + 1'b1) >= LOAD_LIMIT;
    assign s_has_now   = r_hit && r_has[r_idx];
    assign s_need_alloc = !s_has_now && (r_blk != BLK_AIR);
    assign s_can_alloc = (r_top != '0);
    assign s_pop       = r_stack[SL_W'(r_top - 1'b1)];
    assign s_key_eq    = (r_rd.kx == r_cx) && (r_rd.ky == r_cy) && (r_rd.kz == r_cz);
    assign s_home      = s_hash[SL_W-1:0];
    assign s_out_load  = (r_state == S_FIN) && (!r_ovalid || i_out_ready);

    // A key belongs where it sits when its home lies cyclically in (hole, j].
    always_comb begin
        if (r_hole < r_idx) begin
            s_in_range = (s_home > r_hole) && (s_home <= r_idx);
        end else begin
            s_in_range = (s_home > r_hole) || (s_home <= r_idx);
        end
    end

    // Hash requests come from a new item or from the shift walk.
    always_comb begin
        s_hash_start = 1'b0;
        s_hx = {{CE_LOG{r_rd.kx[KEY_W-1]}}, r_rd.kx};
        s_hy = {{CE_LOG{r_rd.ky[KEY_W-1]}}, r_rd.ky};
        s_hz = {{CE_LOG{r_rd.kz[KEY_W-1]}}, r_rd.kz};
        if (r_state == S_IDLE) begin
            s_hash_start = s_accept;
            s_hx = {{CE_LOG{i_coord_x[31]}}, i_coord_x[31:CE_LOG]};
            s_hy = {{CE_LOG{i_coord_y[31]}}, i_coord_y[31:CE_LOG]};
            s_hz = {{CE_LOG{i_coord_z[31]}}, i_coord_z[31:CE_LOG]};
        end else if (r_state == S_SKEY) begin
            s_hash_start = 1'b1;
        end
    end

    cvs_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_hash_start),
        .i_key_x (s_hx),
        .i_key_y (s_hy),
        .i_key_z (s_hz),
        .o_done  (s_hash_done),
        .o_hash  (s_hash)
    );

    // Memory port controls.
    always_comb begin
        s_slot_re    = 1'b0;
        s_slot_we    = 1'b0;
        s_slot_waddr = r_idx;
        s_slot_wdata = '{kx: r_cx, ky: r_cy, kz: r_cz, buf_idx: r_buf};
        s_vwe        = 1'b0;
        s_vre        = 1'b0;
        s_vaddr      = {r_buf, r_loc};
        s_vdata      = r_blk;
        case (r_state)
            S_PRD: begin
                s_slot_re = (r_n != CNT_W'(TABLE_SLOTS)) && r_used[r_idx];
            end
            S_SRD: begin
                s_slot_re = (r_n != CNT_W'(TABLE_SLOTS)) && r_used[r_idx];
            end
            S_EXEC: begin
                if (r_mode == MODE_SET && r_blk <= MAX_BLOCK && (r_hit || !s_full)) begin
                    // Insert the key, attach a fresh buffer, or both in one write.
                    s_slot_we = !r_hit || (s_need_alloc && s_can_alloc);
                    if (s_need_alloc && s_can_alloc) begin
                        s_slot_wdata.buf_idx = s_pop;
                    end
                end
                if (r_mode == MODE_GET) begin
                    s_vre = r_hit && r_has[r_idx];
                end
            end
            S_CLR: begin
                s_vwe   = 1'b1;
                s_vaddr = {r_buf, r_clr};
                s_vdata = BLK_AIR;
            end
            S_VWR: begin
                s_vwe = 1'b1;
            end
            S_SHASH: begin
                s_slot_we    = s_hash_done && !s_in_range;
                s_slot_waddr = r_hole;
                s_slot_wdata = r_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_slot_we) begin
            m_slot[s_slot_waddr] <= s_slot_wdata;
        end
        if (s_slot_re) begin
            r_rd <= m_slot[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_vwe) begin
            m_vox[s_vaddr] <= s_vdata;
        end
        if (s_vre) begin
            r_vrd <= m_vox[s_vaddr];
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_has    <= '0;
            r_top    <= CNT_W'(TABLE_SLOTS);
            r_occ    <= '0;
            r_filled <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_stack[i] <= SL_W'(i);
            end
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_mode  <= i_mode;
                        r_blk   <= i_block_value;
                        r_cx    <= i_coord_x[31:CE_LOG];
                        r_cy    <= i_coord_y[31:CE_LOG];
                        r_cz    <= i_coord_z[31:CE_LOG];
                        r_loc   <= {i_coord_z[CE_LOG-1:0], i_coord_y[CE_LOG-1:0],
                                    i_coord_x[CE_LOG-1:0]};
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (s_hash_done) begin
                        r_idx   <= s_home;
                        r_n     <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    if (r_n == CNT_W'(TABLE_SLOTS) || !r_used[r_idx]) begin
                        r_hit   <= 1'b0;
                        r_state <= S_EXEC;
                    end else begin
                        r_state <= S_PCMP;
                    end
                end
                S_PCMP: begin
                    if (s_key_eq) begin
                        r_hit   <= 1'b1;
                        r_buf   <= r_rd.buf_idx;
                        r_state <= S_EXEC;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                S_EXEC: begin
                    r_status <= ST_OK;
                    r_readv  <= BLK_AIR;
                    r_state  <= S_FIN;
                    case (r_mode)
                        MODE_SET: begin
                            if (r_blk > MAX_BLOCK) begin
                                r_status <= ST_BADBLK;
                            end else if (!r_hit && s_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                if (!r_hit) begin
                                    r_used[r_idx] <= 1'b1;
                                    r_has[r_idx]  <= 1'b0;
                                    r_occ         <= r_occ + 1'b1;
                                end
                                if (s_need_alloc) begin
                                    if (!s_can_alloc) begin
                                        r_status <= ST_FULL;
                                    end else begin
                                        r_buf         <= s_pop;
                                        r_top         <= r_top - 1'b1;
                                        r_has[r_idx]  <= 1'b1;
                                        r_filled      <= r_filled + 1'b1;
                                        r_clr         <= '0;
                                        r_state       <= S_CLR;
                                    end
                                end else if (s_has_now) begin
                                    r_state <= S_VWR;
                                end
                            end
                        end
                        MODE_GET: begin
                            if (r_hit && r_has[r_idx]) begin
                                r_state <= S_VRD;
                            end
                        end
                        MODE_UNLOAD: begin
                            if (!r_hit) begin
                                r_status <= ST_ABSENT;
                            end else begin
                                if (r_has[r_idx]) begin
                                    if (r_top != CNT_W'(TABLE_SLOTS)) begin
                                        r_stack[r_top[SL_W-1:0]] <= r_buf;
                                        r_top <= r_top + 1'b1;
                                    end
                                    r_filled <= r_filled - 1'b1;
                                end
                                r_has[r_idx]  <= 1'b0;
                                r_used[r_idx] <= 1'b0;
                                r_occ         <= r_occ - 1'b1;
                                r_hole        <= r_idx;
                                r_idx         <= r_idx + 1'b1;
                                r_n           <= '0;
                                r_state       <= S_SRD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {LOC_W{1'b1}}) begin
                        r_state <= S_VWR;
                    end
                end
                S_VWR: begin
                    r_state <= S_FIN;
                end
                S_VRD: begin
                    r_readv <= r_vrd;
                    r_state <= S_FIN;
                end
                S_SRD: begin
                    if (r_n == CNT_W'(TABLE_SLOTS) || !r_used[r_idx]) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SKEY;
                    end
                end
                S_SKEY: begin
                    r_state <= S_SHASH;
                end
                S_SHASH: begin
                    if (s_hash_done) begin
                        if (!s_in_range) begin
                            r_used[r_hole] <= 1'b1;
                            r_has[r_hole]  <= r_has[r_idx];
                            r_used[r_idx]  <= 1'b0;
                            r_has[r_idx]   <= 1'b0;
                            r_hole         <= r_idx;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_FIN: begin
                    if (s_out_load) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result payload, loaded when the output register is free.
    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_ostat <= r_status;
            r_oread <= r_readv;
            r_opres <= r_occ;
            r_ofill <= r_filled;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostat;
    assign o_read_value     = r_oread;
    assign o_chunks_present = r_opres;
    assign o_chunks_filled  = r_ofill;

`ifndef SYNTHESIS
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == r_occ)
        else $error("occupancy count disagrees with slot valid bits");
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_has) == r_filled)
        else $error("filled count disagrees with buffer bits");
    a_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top + r_filled) == CNT_W'(TABLE_SLOTS))
        else $error("buffer pool lost or duplicated a buffer");
    a_has_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_has & ~r_used) == '0)
        else $error("buffer owned by an empty slot");
`endif

endmodule
`default_nettype wire
